// ===== sv/rag_pkg.sv =====
// Shared codes, command and status types for the rational accumulator.
package rag_pkg;

  localparam logic [2:0] OP_LOAD = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] MSEL_CROSS_A = 2'd0;
  localparam logic [1:0] MSEL_CROSS_B = 2'd1;
  localparam logic [1:0] MSEL_DEN     = 2'd2;

  typedef struct packed {
    logic       start;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       comb;
    logic       pre;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       fin;
  } rag_cmd_t;

  typedef struct packed {
    logic early;
    logic n_zero;
    logic both_even;
    logic u_zero;
  } rag_sts_t;

endpackage

// ===== sv/rational_accumulator_gcd_reduce.sv =====
// Top level of the rational accumulator with GCD reduction.
// Usage:
//   Input channel in_valid/in_ready carries an operation (load, add, subtract,
//   multiply, divide) and a signed operand fraction. Each transfer yields one
//   result transfer on out_valid/out_ready: the reduced accumulator and status.
//   in_ready is high only while no item is in work; one item at a time.
// Steps per item:
//   Unknown operation or zero denominator: the result goes from the multiply
//   state straight to the output register. Otherwise the shared 32x32
//   multiplier forms the cross and denominator products, a combine step
//   follows, common powers of two are removed (one shift per cycle plus a final
//   check), the binary GCD loop runs (one subtract or shift per cycle), then the
//   two restoring dividers, and last the write to the output register. A zero
//   result skips the power-of-two, GCD and divide steps.
//   The binary GCD loop sets the item rate.
// Reset: accumulator becomes 0/1, no result pending.
// Stalls: a result waits in the output register; the next item may already
//   be accepted and runs until its own result is ready to be written.
module rational_accumulator_gcd_reduce
  import rag_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_operand_numerator,
  input  logic signed [31:0] in_operand_denominator,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_numerator,
  output logic [30:0]        out_result_denominator,
  output logic [1:0]         out_status
);

  rag_cmd_t cmd;
  rag_sts_t sts;

  rag_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rag_dp #(.WIDTH(WIDTH)) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_operation           (in_operation),
    .in_operand_numerator   (in_operand_numerator),
    .in_operand_denominator (in_operand_denominator),
    .out_result_numerator   (out_result_numerator),
    .out_result_denominator (out_result_denominator),
    .out_status             (out_status),
    .cmd                    (cmd),
    .sts                    (sts)
  );

endmodule

// ===== sv/rag_ctrl.sv =====
// Sequencing state machine for the rational accumulator.
module rag_ctrl
  import rag_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rag_sts_t sts,
  output rag_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_COMB = 3'd2;
  localparam logic [2:0] S_PRE  = 3'd3;
  localparam logic [2:0] S_GCD  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.early) begin
          state_nxt = S_FIN;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = cnt_r[1:0];
          cnt_nxt     = cnt_r + 6'd1;
          if (cnt_r[1:0] == MSEL_DEN) state_nxt = S_COMB;
        end
      end
      S_COMB: begin
        cmd.comb  = 1'b1;
        state_nxt = sts.n_zero ? S_FIN : S_PRE;
      end
      S_PRE: begin
        if (sts.both_even) cmd.pre = 1'b1;
        else state_nxt = S_GCD;
      end
      S_GCD: begin
        if (sts.u_zero) begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'd63) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_fin_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while held");

  a_fin_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r)
    else $error("finished result not presented");

  a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL))
    else $error("transfer did not start work");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == 6'd63) |=> (state_r == S_FIN))
    else $error("division length wrong");

endmodule

// ===== sv/rag_dp.sv =====
// Datapath: operand decode, shared multiplier, binary GCD, dividers, accumulator.
module rag_dp
  import rag_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_operand_numerator,
  input  logic signed [31:0] in_operand_denominator,
  output logic signed [31:0] out_result_numerator,
  output logic [30:0]        out_result_denominator,
  output logic [1:0]         out_status,
  input  rag_cmd_t           cmd,
  output rag_sts_t           sts
);

  localparam logic [63:0] LIMIT = (64'd1 << (WIDTH - 1)) - 64'd1;

  logic [31:0] acc_n_r, acc_d_r;
  logic        early_r;
  logic [1:0]  early_code_r;
  logic        is_load_r, is_addsub_r;
  logic [31:0] on_mag_r, od_mag_r, an_mag_r, ad_mag_r;
  logic        on_neg_r, od_neg_r, an_neg_r, ad_neg_r;
  logic [63:0] m1_r, m2_r, dm_r;
  logic [63:0] u_r, v_r, n_r, d_r, g_r;
  logic [5:0]  k_r;
  logic [63:0] qn_r, qd_r, rn_r, rd_r;
  logic        res_neg_r;
  logic signed [31:0] o_n_r;
  logic [30:0] o_d_r;
  logic [1:0]  o_st_r;

  logic [31:0] on_s, od_s, a_mul, b_mul;
  logic        sw;
  logic [63:0] prod;
  logic        s1, s2, c_nneg, c_dneg;
  logic [63:0] c_nmag, c_dmag;
  logic [63:0] tn, td;
  logic [31:0] fin_n;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    mag32 = x[31] ? (32'd0 - x) : x;
  endfunction

  always_comb begin
    sw   = (in_operation == OP_DIV);
    on_s = sw ? in_operand_denominator : in_operand_numerator;
    od_s = sw ? in_operand_numerator : in_operand_denominator;
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_CROSS_A: begin a_mul = an_mag_r; b_mul = is_addsub_r ? od_mag_r : on_mag_r; end
      MSEL_CROSS_B: begin a_mul = on_mag_r; b_mul = ad_mag_r; end
      default:      begin a_mul = ad_mag_r; b_mul = od_mag_r; end
    endcase
    prod = {32'd0, a_mul} * {32'd0, b_mul};
  end

  always_comb begin
    s1 = an_neg_r ^ od_neg_r;
    s2 = on_neg_r ^ ad_neg_r;
    if (is_load_r) begin
      c_nneg = on_neg_r;
      c_nmag = {32'd0, on_mag_r};
      c_dneg = od_neg_r;
      c_dmag = {32'd0, od_mag_r};
    end else if (is_addsub_r) begin
      c_dneg = ad_neg_r ^ od_neg_r;
      c_dmag = dm_r;
      if (s1 == s2) begin
        c_nneg = s1;
        c_nmag = m1_r + m2_r;
      end else if (m1_r >= m2_r) begin
        c_nneg = s1;
        c_nmag = m1_r - m2_r;
      end else begin
        c_nneg = s2;
        c_nmag = m2_r - m1_r;
      end
    end else begin
      c_nneg = an_neg_r ^ on_neg_r;
      c_nmag = m1_r;
      c_dneg = ad_neg_r ^ od_neg_r;
      c_dmag = dm_r;
    end
  end

  assign tn = {rn_r[62:0], qn_r[63]};
  assign td = {rd_r[62:0], qd_r[63]};
  assign fin_n = res_neg_r ? (32'd0 - qn_r[31:0]) : qn_r[31:0];

  assign sts.early     = early_r;
  assign sts.n_zero    = (c_nmag == 64'd0);
  assign sts.both_even = !u_r[0] && !v_r[0];
  assign sts.u_zero    = (u_r == 64'd0);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      is_load_r   <= (in_operation == OP_LOAD);
      is_addsub_r <= (in_operation == OP_ADD) || (in_operation == OP_SUB);
      on_mag_r    <= mag32(on_s);
      on_neg_r    <= on_s[31] ^ (in_operation == OP_SUB);
      od_mag_r    <= mag32(od_s);
      od_neg_r    <= od_s[31];
      an_mag_r    <= mag32(acc_n_r);
      an_neg_r    <= acc_n_r[31];
      ad_mag_r    <= mag32(acc_d_r);
      ad_neg_r    <= acc_d_r[31];
      early_code_r <= ST_OK;
      early_r      <= 1'b0;
      if (in_operation > OP_DIV) begin
        early_r <= 1'b1;
      end else if (in_operand_denominator == 32'sd0 ||
                   (sw && in_operand_numerator == 32'sd0)) begin
        early_r      <= 1'b1;
        early_code_r <= ST_ZERO_DEN;
      end
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_sel)
        MSEL_CROSS_A: m1_r <= prod;
        MSEL_CROSS_B: m2_r <= prod;
        default:      dm_r <= prod;
      endcase
    end
    if (cmd.comb) begin
      u_r <= c_nmag;
      v_r <= c_dmag;
      n_r <= c_nmag;
      d_r <= c_dmag;
      k_r <= '0;
      if (c_nmag == 64'd0) begin
        res_neg_r <= 1'b0;
        qn_r      <= 64'd0;
        qd_r      <= 64'd1;
      end else begin
        res_neg_r <= c_nneg ^ c_dneg;
      end
    end
    if (cmd.pre) begin
      u_r <= {1'b0, u_r[63:1]};
      v_r <= {1'b0, v_r[63:1]};
      k_r <= k_r + 6'd1;
    end
    if (cmd.gcd_step) begin
      if (!u_r[0]) u_r <= {1'b0, u_r[63:1]};
      else if (!v_r[0]) v_r <= {1'b0, v_r[63:1]};
      else if (u_r >= v_r) u_r <= u_r - v_r;
      else v_r <= v_r - u_r;
    end
    if (cmd.div_init) begin
      g_r  <= v_r << k_r;
      qn_r <= n_r;
      qd_r <= d_r;
      rn_r <= '0;
      rd_r <= '0;
    end
    if (cmd.div_step) begin
      if (tn >= g_r) begin
        rn_r <= tn - g_r;
        qn_r <= {qn_r[62:0], 1'b1};
      end else begin
        rn_r <= tn;
        qn_r <= {qn_r[62:0], 1'b0};
      end
      if (td >= g_r) begin
        rd_r <= td - g_r;
        qd_r <= {qd_r[62:0], 1'b1};
      end else begin
        rd_r <= td;
        qd_r <= {qd_r[62:0], 1'b0};
      end
    end
    if (cmd.fin) begin
      if (early_r) begin
        o_st_r <= early_code_r;
        o_n_r  <= acc_n_r;
        o_d_r  <= acc_d_r[30:0];
      end else if (qn_r > LIMIT || qd_r > LIMIT) begin
        o_st_r <= ST_OVERFLOW;
        o_n_r  <= acc_n_r;
        o_d_r  <= acc_d_r[30:0];
      end else begin
        o_st_r <= ST_OK;
        o_n_r  <= fin_n;
        o_d_r  <= qd_r[30:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_n_r <= 32'd0;
      acc_d_r <= 32'd1;
    end else if (cmd.fin && !early_r && !(qn_r > LIMIT || qd_r > LIMIT)) begin
      acc_n_r <= fin_n;
      acc_d_r <= qd_r[31:0];
    end
  end

  assign out_result_numerator   = o_n_r;
  assign out_result_denominator = o_d_r;
  assign out_status             = o_st_r;

endmodule

// ===== tb/sv/tb_rational_accumulator_gcd_reduce.sv =====
// Testbench for the rational accumulator: random and directed fractions, self-predicted results.
module tb_rational_accumulator_gcd_reduce;
  timeunit 1ns;
  timeprecision 1ps;
  import rag_pkg::*;

  localparam int HOLD_CYCLES = 800;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int TAIL_CYCLES = 600;
  localparam int PHASE_ITEMS = 385;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } frac_item_t;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic [1:0]         status;
  } frac_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_operation = OP_LOAD;
  logic signed [31:0] in_operand_numerator = '0;
  logic signed [31:0] in_operand_denominator = 32'sd1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_result_numerator;
  logic [30:0]        out_result_denominator;
  logic [1:0]         out_status;

  frac_item_t   pending_items[$];
  frac_result_t expected_results[$];
  frac_item_t   offered;
  logic signed [31:0] acc_num = '0;
  logic signed [31:0] acc_den = 32'sd1;
  int idle_in_pct = 0;
  int stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  rational_accumulator_gcd_reduce i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] mag(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // Predicts one item and updates the accumulator copy.
  function automatic frac_result_t fraction_step(frac_item_t it);
    longint an, ad, on, od, t;
    bit nneg, dneg, s1, s2;
    logic [63:0] nmag, dmag, m1, m2, a, b, r;
    frac_result_t rs;
    an = acc_num;
    ad = acc_den;
    on = it.num;
    od = it.den;
    rs = '{acc_num, acc_den[30:0], ST_OK};
    if (it.op > OP_DIV) return rs;
    if (od == 0 || (it.op == OP_DIV && on == 0)) begin
      rs.status = ST_ZERO_DEN;
      return rs;
    end
    if (it.op == OP_DIV) begin
      t = on;
      on = od;
      od = t;
    end
    if (it.op == OP_SUB) on = -on;
    if (it.op == OP_LOAD) begin
      nneg = on < 0;
      nmag = mag(on);
      dneg = od < 0;
      dmag = mag(od);
    end else if (it.op == OP_ADD || it.op == OP_SUB) begin
      s1 = (an < 0) != (od < 0);
      m1 = mag(an) * mag(od);
      s2 = (on < 0) != (ad < 0);
      m2 = mag(on) * mag(ad);
      if (s1 == s2) begin
        nneg = s1;
        nmag = m1 + m2;
      end else if (m1 >= m2) begin
        nneg = s1;
        nmag = m1 - m2;
      end else begin
        nneg = s2;
        nmag = m2 - m1;
      end
      dneg = (ad < 0) != (od < 0);
      dmag = mag(ad) * mag(od);
    end else begin
      nneg = (an < 0) != (on < 0);
      nmag = mag(an) * mag(on);
      dneg = (ad < 0) != (od < 0);
      dmag = mag(ad) * mag(od);
    end
    if (dmag == 0) begin
      rs.status = ST_ZERO_DEN;
      return rs;
    end
    if (nmag == 0) begin
      nneg = 1'b0;
      dmag = 1;
    end else begin
      a = nmag;
      b = dmag;
      while (b != 0) begin
        r = a % b;
        a = b;
        b = r;
      end
      nmag = nmag / a;
      dmag = dmag / a;
      if (dneg) nneg = !nneg;
    end
    if (nmag > 64'h7FFF_FFFF || dmag > 64'h7FFF_FFFF) begin
      rs.status = ST_OVERFLOW;
      return rs;
    end
    acc_num = nneg ? -$signed(nmag[31:0]) : $signed(nmag[31:0]);
    acc_den = dmag[31:0];
    return '{acc_num, acc_den[30:0], ST_OK};
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: case ($urandom_range(5))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h8000_0001;
           3: return 32'hFFFF_FFFF;
           4: return 32'd0;
           default: return 32'd1;
         endcase
      3: return 32'($signed($urandom_range(131072)) - 65536);
      default: return 32'($signed($urandom_range(40)) - 20);
    endcase
  endfunction

  function automatic frac_item_t rand_item();
    frac_item_t it;
    int sel;
    sel = $urandom_range(99);
    if (sel < 25) it.op = OP_LOAD;
    else if (sel < 95) it.op = 3'($urandom_range(OP_DIV, OP_ADD));
    else it.op = 3'($urandom_range(7, 5));
    it.num = rand_operand();
    it.den = rand_operand();
    return it;
  endfunction

  task automatic push(logic [2:0] op, logic [31:0] n, logic [31:0] d);
    pending_items.push_back('{op, n, d});
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(fraction_step(offered));
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
          offered = pending_items.pop_front();
          in_operation <= offered.op;
          in_operand_numerator <= offered.num;
          in_operand_denominator <= offered.den;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready, with the long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= stall_pct;
    end
  end

  // Result checker
  always @(posedge clk) begin
    frac_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer %0d/%0d st %0d", out_result_numerator,
                   out_result_denominator, out_status);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_result_numerator !== exp_r.num || out_result_denominator !== exp_r.den
            || out_status !== exp_r.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0d st %0d, got %0d/%0d st %0d", exp_r.num,
                     exp_r.den, exp_r.status, out_result_numerator,
                     out_result_denominator, out_status);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL rational_accumulator_gcd_reduce");
      $finish;
    end
  end

  initial begin
    int ph;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    push(OP_LOAD, 32'd3, 32'hFFFF_FFFA);
    push(OP_ADD, 32'd1, 32'd3);
    push(OP_SUB, 32'd5, 32'hFFFF_FFFE);
    push(OP_MUL, 32'hFFFF_FFFD, 32'd7);
    push(OP_DIV, 32'd2, 32'hFFFF_FFF9);
    push(OP_DIV, 32'd0, 32'd5);
    push(OP_ADD, 32'd1, 32'd0);
    push(3'd5, 32'd9, 32'd9);
    push(3'd6, 32'h8000_0000, 32'd0);
    push(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(OP_MUL, 32'd0, 32'd9);
    push(OP_LOAD, 32'h7FFF_FFFF, 32'd1);
    push(OP_ADD, 32'd1, 32'd1);
    push(OP_LOAD, 32'h8000_0001, 32'h7FFF_FFFF);
    push(OP_LOAD, 32'h8000_0000, 32'd1);
    push(OP_LOAD, 32'h8000_0000, 32'h8000_0000);
    push(OP_LOAD, 32'd1, 32'h7FFF_FFFF);
    push(OP_MUL, 32'd1, 32'd2);
    push(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF);
    push(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    push(OP_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
    push(OP_MUL, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
    push(OP_LOAD, 32'd0, 32'hFFFF_FFFF);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_in_pct = 0;  stall_pct = 0;  end
        1: begin idle_in_pct = 52; stall_pct = 0;  end
        2: begin idle_in_pct = 0;  stall_pct = 52; end
        default: begin idle_in_pct = 37; stall_pct = 37; end
      endcase
      if (ph == 0) hold_token++;
      repeat (PHASE_ITEMS) pending_items.push_back(rand_item());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS rational_accumulator_gcd_reduce");
    end else begin
      $display("FAIL rational_accumulator_gcd_reduce");
    end
    $finish;
  end

endmodule
